@@ design/csp_pkg.sv @@
// shared types, constants and helper functions for the category softmax block
package csp_pkg;

  localparam int CatW    = 4;
  localparam int CoefW   = 16;
  localparam int ProdW   = 32;
  localparam int LogitW  = 36;
  localparam int ExpW    = 17;
  localparam int SumW    = 22;
  localparam int ProbW   = 16;
  localparam int QuoW    = 17;
  localparam int NumW    = 33;

  localparam logic signed [LogitW-1:0] SatHi = 36'sh7_FFFF_FFFF;
  localparam logic signed [LogitW-1:0] SatLo = 36'sh8_0000_0000;
  localparam logic [SumW-1:0]          SumMax = 22'h3F_FFFF;
  localparam logic [16:0]              Log2eQ16 = 17'd94548;
  localparam logic [QuoW-1:0]          ProbSat = 17'd65535;

  // queued term between front and back
  typedef struct packed {
    logic [CatW-1:0]         category;
    logic                    term_kind;
    logic signed [ProdW-1:0] prod;
    logic                    last_term;
    logic                    last_category;
  } csp_term_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_MAX,
    ST_EXP_T,
    ST_EXP_M,
    ST_EXP_W,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_CLEAR
  } csp_state_e;

  function automatic logic signed [LogitW-1:0] sat_add36(
      input logic signed [LogitW-1:0] a, input logic signed [ProdW-1:0] b);
    logic signed [LogitW:0] s;
    s = {a[LogitW-1], a} + (LogitW+1)'(b);
    if (s > $signed({1'b0, SatHi})) return SatHi;
    if (s < $signed({1'b1, SatLo})) return SatLo;
    return s[LogitW-1:0];
  endfunction

  // round(65536 * 2^(-k/16))
  function automatic logic [ExpW-1:0] pow2_val(input logic [4:0] k);
    logic [ExpW-1:0] v;
    unique case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/csp_front.sv @@
// front end: takes terms, forms the product and queues it for the back end
module csp_front
  import csp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CatW-1:0] category_i,
  input  logic            term_kind_i,
  input  logic [CoefW-1:0] coefficient_i,
  input  logic [CoefW-1:0] multiplier_i,
  input  logic            last_term_i,
  input  logic            last_category_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output csp_term_t       q_term_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  csp_term_t       fifo_q [Depth];
  logic [PtrW:0]   wr_q, rd_q;
  logic            full, empty, push;
  csp_term_t       wr_term;

  assign empty      = (wr_q == rd_q);
  assign full       = (wr_q[PtrW] != rd_q[PtrW]) && (wr_q[PtrW-1:0] == rd_q[PtrW-1:0]);
  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;
  assign q_valid_o  = !empty;
  assign q_term_o   = fifo_q[rd_q[PtrW-1:0]];

  always_comb begin
    wr_term.category      = category_i;
    wr_term.term_kind     = term_kind_i;
    wr_term.prod          = $signed(coefficient_i) * $signed(multiplier_i);
    wr_term.last_term     = last_term_i;
    wr_term.last_category = last_category_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q[PtrW-1:0]] <= wr_term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i && !empty) rd_q <= rd_q + 1'b1;
    end
  end

endmodule

@@ design/csp_div.sv @@
// restoring divider, one quotient bit per cycle
module csp_div
  import csp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [SumW-1:0] den_i,
  output logic            done_o,
  output logic [QuoW-1:0] quo_o
);

  logic [SumW-1:0] rem_q;
  logic [QuoW-1:0] quo_q;
  logic [SumW-1:0] den_q;
  logic [4:0]      cnt_q;
  logic            busy_q, done_q;
  logic [SumW:0]   rem2;
  logic            ge;

  assign rem2 = {rem_q, quo_q[QuoW-1]};
  assign ge   = (rem2 >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= SumW'(num_i[NumW-1:QuoW]);
      quo_q <= num_i[QuoW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? SumW'(rem2 - {1'b0, den_q}) : rem2[SumW-1:0];
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QuoW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ design/csp_back.sv @@
// back end: accumulates logits and runs the softmax pass at each group end
module csp_back
  import csp_pkg::*;
#(
  parameter int MaxCategories = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  csp_term_t       q_term_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CatW-1:0] out_category_o,
  output logic [LogitW-1:0] intercept_sum_o,
  output logic [ProbW-1:0] probability_o,
  output logic            last_result_o
);

  localparam int NumSlots = (MaxCategories < 16) ? MaxCategories : 16;
  localparam int IdxW     = $clog2(NumSlots);
  localparam int CntW     = $clog2(NumSlots + 1);

  csp_state_e state_q, state_d;

  logic signed [LogitW-1:0] logit_q [NumSlots];
  logic signed [LogitW-1:0] icpt_q  [NumSlots];
  logic [ExpW-1:0]          exp_q   [NumSlots];
  logic [NumSlots-1:0]      used_q;

  logic signed [LogitW-1:0] max_q;
  logic [SumW-1:0]          sum_q;
  logic [CntW-1:0]          count_q, k_q;
  logic [28:0]              t_q;
  logic [23:0]              dprod_q;
  logic [ProbW-1:0]         prob_q;

  logic                     ovalid_q, olast_q;
  logic [CatW-1:0]          ocat_q;
  logic [LogitW-1:0]        oicpt_q;
  logic [ProbW-1:0]         oprob_q;

  logic                     in_range, close, last_k, slot_free;
  logic [IdxW-1:0]          rd_idx, cat_idx;
  logic signed [LogitW-1:0] logit_rd, icpt_rd;
  logic [CntW-1:0]          cnt_new;
  logic                     div_start, div_done;
  logic [QuoW-1:0]          div_quo;
  logic [NumW-1:0]          div_num;
  logic signed [LogitW:0]   diff;
  logic [44:0]              tprod;
  logic [3:0]               tab_i;
  logic [ExpW-1:0]          tab_lo, tab_hi, interp, exp_val;
  logic [12:0]              shift_n;
  logic [SumW:0]            sum_ext;

  assign in_range  = (32'(q_term_i.category) < NumSlots);
  assign cat_idx   = IdxW'(q_term_i.category);
  assign close     = q_term_i.last_term && q_term_i.last_category;
  assign cnt_new   = (32'(q_term_i.category) + 1 > NumSlots) ? CntW'(NumSlots)
                                                             : CntW'(32'(q_term_i.category) + 1);
  assign last_k    = (k_q == CntW'(count_q - 1'b1));
  assign slot_free = !ovalid_q || out_ready_i;

  assign rd_idx   = (state_q == ST_ACC) ? cat_idx : k_q[IdxW-1:0];
  assign logit_rd = used_q[rd_idx] ? logit_q[rd_idx] : '0;
  assign icpt_rd  = used_q[rd_idx] ? icpt_q[rd_idx] : '0;

  // exponential datapath
  assign diff    = {max_q[LogitW-1], max_q} - {logit_rd[LogitW-1], logit_rd};
  assign tprod   = diff[LogitW-1:8] * Log2eQ16;
  assign shift_n = t_q[28:16];
  assign tab_i   = t_q[15:12];
  assign tab_lo  = pow2_val({1'b0, tab_i});
  assign tab_hi  = pow2_val(5'({1'b0, tab_i}) + 5'd1);
  assign interp  = tab_lo - ExpW'((25'(dprod_q) + 25'd2048) >> 12);
  assign exp_val = (shift_n >= 13'd17) ? '0 : (interp >> shift_n[4:0]);
  assign sum_ext = {1'b0, sum_q} + (SumW+1)'(exp_val);

  assign div_num = {exp_q[k_q[IdxW-1:0]], 16'b0} + NumW'(sum_q >> 1);

  csp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (sum_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (close) state_d = ST_MAX;
        end
      end
      ST_MAX:      if (last_k) state_d = ST_EXP_T;
      ST_EXP_T:    state_d = ST_EXP_M;
      ST_EXP_M:    state_d = ST_EXP_W;
      ST_EXP_W:    state_d = last_k ? ST_DIV_GO : ST_EXP_T;
      ST_DIV_GO: begin
        if (sum_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: if (div_done) state_d = ST_EMIT;
      ST_EMIT:     if (slot_free) state_d = last_k ? ST_CLEAR : ST_DIV_GO;
      ST_CLEAR:    state_d = ST_ACC;
      default:     state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_ACC;
    else         state_q <= state_d;
  end

  // store arrays, no reset: entries beyond used_q read as zero
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC && q_valid_i && in_range) begin
      logit_q[cat_idx] <= sat_add36(logit_rd, q_term_i.prod);
      // slope terms still write the slot so a stale sum never shows through
      icpt_q[cat_idx]  <= q_term_i.term_kind ? icpt_rd : sat_add36(icpt_rd, q_term_i.prod);
    end
    if (state_q == ST_EXP_W) exp_q[k_q[IdxW-1:0]] <= exp_val;
    if (state_q == ST_EXP_T) t_q <= tprod[44:16];
    if (state_q == ST_EXP_M) dprod_q <= 12'(tab_lo - tab_hi) * t_q[11:0];
    if (state_q == ST_DIV_GO) prob_q <= '0;
    if (state_q == ST_DIV_WAIT && div_done) begin
      prob_q <= (div_quo > ProbSat) ? ProbSat[ProbW-1:0] : div_quo[ProbW-1:0];
    end
    if (state_q == ST_EMIT && slot_free) begin
      ocat_q  <= CatW'(k_q);
      oicpt_q <= icpt_rd;
      oprob_q <= prob_q;
      olast_q <= last_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      max_q    <= '0;
      sum_q    <= '0;
      count_q  <= '0;
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_ACC: begin
          if (q_valid_i) begin
            if (in_range) used_q[cat_idx] <= 1'b1;
            if (q_term_i.last_category) count_q <= cnt_new;
            k_q <= '0;
          end
        end
        ST_MAX: begin
          if (k_q == '0 || logit_rd > max_q) max_q <= logit_rd;
          k_q <= last_k ? '0 : k_q + 1'b1;
        end
        ST_EXP_W: begin
          sum_q <= (sum_ext > {1'b0, SumMax}) ? SumMax : sum_ext[SumW-1:0];
          k_q   <= last_k ? '0 : k_q + 1'b1;
        end
        ST_EMIT: begin
          if (slot_free) begin
            ovalid_q <= 1'b1;
            k_q      <= k_q + 1'b1;
          end
        end
        ST_CLEAR: begin
          used_q  <= '0;
          max_q   <= '0;
          sum_q   <= '0;
          count_q <= '0;
          k_q     <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = ovalid_q;
  assign out_category_o  = ocat_q;
  assign intercept_sum_o = oicpt_q;
  assign probability_o   = oprob_q;
  assign last_result_o   = olast_q;

endmodule

@@ design/category_softmax_probability_top.sv @@
// top level of the category softmax probability block
//
// input stream: one product term per word (category, coefficient and
// multiplier in tdata, term kind and last-category flag in tuser, last
// term of a category on tlast); categories arrive in ascending order
// output stream: one word per category at each group end, category 0 first,
// carrying the intercept sum and the probability; tlast marks the last one
// intake: terms enter a four-word queue; while it is accumulating, the back
// end folds one queued term per cycle into the logit and intercept sums
// group end: with n categories the back end runs the max search, the
// exponentials (two multipliers in series), then for each category the
// divide (17 iterations) and emit, and finally clears the stores; terms
// queue up meanwhile until the queue fills
// stall: a stalled receiver holds the output word and the back end waits;
// the front keeps accepting terms while the queue has room
// reset: queue emptied, all sums zero, no word pending
module category_softmax_probability_top
  import csp_pkg::*;
#(
  parameter int MAX_CATEGORIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] category, [19:4] coefficient, [35:20] multiplier, [39:36] zero
  input  logic [39:0] s_axis_tdata_i,
  // [0] term_kind, [1] last_category
  input  logic [1:0]  s_axis_tuser_i,
  // last_term
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] out_category, [39:4] intercept_sum, [55:40] probability
  output logic [55:0] m_axis_tdata_o,
  // last_result
  output logic        m_axis_tlast_o
);

  logic            q_valid, q_pop;
  csp_term_t       q_term;
  logic [CatW-1:0] out_cat;
  logic [LogitW-1:0] out_icpt;
  logic [ProbW-1:0]  out_prob;

  // term intake and product queue
  csp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .category_i     (s_axis_tdata_i[3:0]),
    .term_kind_i    (s_axis_tuser_i[0]),
    .coefficient_i  (s_axis_tdata_i[19:4]),
    .multiplier_i   (s_axis_tdata_i[35:20]),
    .last_term_i    (s_axis_tlast_i),
    .last_category_i(s_axis_tuser_i[1]),
    .q_valid_o      (q_valid),
    .q_pop_i        (q_pop),
    .q_term_o       (q_term)
  );

  // accumulation and softmax sequencer, owns the output register
  csp_back #(
    .MaxCategories(MAX_CATEGORIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_term_i       (q_term),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_category_o (out_cat),
    .intercept_sum_o(out_icpt),
    .probability_o  (out_prob),
    .last_result_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_prob, out_icpt, out_cat};

endmodule

@@ design/csp_checker.sv @@
// port-level checker for the category softmax block, bound to the top level
module csp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [39:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic       first_q;
  logic [3:0] prev_q;

  // track position within the current run of results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      prev_q  <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      first_q <= m_axis_tlast_o;
      prev_q  <= m_axis_tdata_o[3:0];
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  a_first_cat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && first_q |-> m_axis_tdata_o[3:0] == 4'd0)
    else $error("run does not start at category zero");

  a_next_cat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !first_q |-> m_axis_tdata_o[3:0] == 4'(prev_q + 4'd1))
    else $error("categories not consecutive within a run");

endmodule

bind category_softmax_probability_top csp_checker u_csp_checker (.*);
